/* design/dhkv_pkg.sv */
package dhkv_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_DELETED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME_LO = 64'h00000000000001B3;
  localparam logic [63:0] DJB_SEED     = 64'd5381;

endpackage

/* design/dhkv_if.sv */
interface dhkv_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] key;
  logic [31:0] value;
  modport source (output valid, output op, output key, output value, input ready);
  modport sink (input valid, input op, input key, input value, output ready);
endinterface

interface dhkv_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] value_out;
  modport source (output valid, output status, output value_out, input ready);
  modport sink (input valid, input status, input value_out, output ready);
endinterface

/* design/dhkv_ram.sv */
module dhkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* design/dhkv_queue.sv */
module dhkv_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end
endmodule

/* design/dhkv_front.sv */
module dhkv_front import dhkv_pkg::*; #(
  parameter int TABLE_SIZE  = 251,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_WIDTH = 32,
  parameter int IW = $clog2(TABLE_SIZE),
  parameter int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32,
  parameter int QW = 2 + 64 + SW + 2 * IW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dhkv_req_if.sink      req_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output logic [QW-1:0] push_data_o
);
  localparam int RW = IW + 4;
  localparam int CW = $clog2(KEY_BYTES + 1);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_HASH = 4'b0010,
    F_MOD  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  front_state_e   state_q, state_d;
  logic [1:0]     op_q, op_d;
  logic [63:0]    key_q, key_d, sh_q, sh_d, mask_q, mask_d;
  logic [63:0]    fnv_q, fnv_d, djb_q, djb_d, fx;
  logic [SW-1:0]  val_q, val_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [3:0]     mc_q, mc_d;
  logic [IW-1:0]  r1_q, r1_d, r2_q, r2_d;
  logic [7:0]     cb;

  // Reduces x below m, where x is known to be below 16 * m.
  function automatic logic [RW-1:0] red_mod(input logic [RW-1:0] x, input logic [RW-1:0] m);
    logic [RW-1:0] res;
    res = x;
    for (int k = 1; k < 16; k++) begin
      if (x >= RW'(k) * m) begin
        res = x - RW'(k) * m;
      end
    end
    return res;
  endfunction

  assign cb = sh_q[63:56];
  assign fx = fnv_q ^ {56'd0, cb};

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    key_d   = key_q;
    sh_d    = sh_q;
    mask_d  = mask_q;
    fnv_d   = fnv_q;
    djb_d   = djb_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    mc_d    = mc_q;
    r1_d    = r1_q;
    r2_d    = r2_q;
    unique case (state_q)
      F_IDLE: begin
        if (req_i.valid) begin
          op_d    = req_i.op;
          key_d   = req_i.key;
          sh_d    = req_i.key;
          val_d   = req_i.value[SW-1:0];
          mask_d  = '0;
          fnv_d   = FNV_BASIS;
          djb_d   = DJB_SEED;
          cnt_d   = '0;
          state_d = F_HASH;
        end
      end
      F_HASH: begin
        if (cb == 8'd0 || cnt_q == CW'(KEY_BYTES)) begin
          r1_d    = '0;
          r2_d    = '0;
          mc_d    = '0;
          state_d = F_MOD;
        end else begin
          fnv_d  = (fx << 40) + fx * FNV_PRIME_LO;
          djb_d  = (djb_q << 5) + djb_q + {56'd0, cb};
          mask_d = {8'hFF, mask_q[63:8]};
          sh_d   = sh_q << 8;
          cnt_d  = cnt_q + CW'(1);
        end
      end
      F_MOD: begin
        r1_d  = IW'(red_mod({r1_q, fnv_q[63:60]}, RW'(TABLE_SIZE)));
        r2_d  = IW'(red_mod({r2_q, djb_q[63:60]}, RW'(TABLE_SIZE - 1)));
        fnv_d = fnv_q << 4;
        djb_d = djb_q << 4;
        mc_d  = mc_q + 4'd1;
        if (mc_q == 4'hF) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    sh_q   <= sh_d;
    mask_q <= mask_d;
    fnv_q  <= fnv_d;
    djb_q  <= djb_d;
    val_q  <= val_d;
    cnt_q  <= cnt_d;
    mc_q   <= mc_d;
    r1_q   <= r1_d;
    r2_q   <= r2_d;
  end

  assign req_i.ready  = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_data_o  = {op_q, key_q & mask_q, val_q, r1_q, r2_q + IW'(1)};
endmodule

/* design/dhkv_back.sv */
module dhkv_back import dhkv_pkg::*; #(
  parameter int TABLE_SIZE  = 251,
  parameter int VALUE_WIDTH = 32,
  parameter int IW = $clog2(TABLE_SIZE),
  parameter int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32,
  parameter int QW = 2 + 64 + SW + 2 * IW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  logic [QW-1:0] pop_data_i,
  dhkv_rsp_if.source    rsp_o
);
  localparam int EW = 2 + 64 + SW;
  localparam int PW = $clog2(TABLE_SIZE + 1);
  localparam int UW = $clog2(TABLE_SIZE / 2 + 1);

  typedef enum logic [2:0] {
    B_IDLE   = 3'b001,
    B_PROBE  = 3'b010,
    B_COMMIT = 3'b100
  } back_state_e;

  back_state_e         state_q, state_d;
  logic [1:0]          op_q, op_d, in_op;
  logic [63:0]         norm_q, norm_d, in_norm, rkey;
  logic [SW-1:0]       val_q, val_d, in_val, hit_q, hit_d, rval;
  logic [IW-1:0]       in_home, in_step, step_q, step_d, idx_q, idx_d;
  logic [IW-1:0]       tomb_q, tomb_d, tgt_q, tgt_d, raddr, nidx;
  logic [IW:0]         nsum;
  logic [PW-1:0]       cnt_q, cnt_d;
  logic                tvld_q, tvld_d, tgtv_q, tgtv_d, found_q, found_d;
  logic [UW-1:0]       used_q, used_d;
  logic [TABLE_SIZE-1:0] slot_vld_q, slot_vld_d;
  logic                out_vld_q, out_vld_d;
  logic [2:0]          status_q, status_d;
  logic [31:0]         vout_q, vout_d;
  logic                we;
  logic [EW-1:0]       wdata, rdata;
  logic [1:0]          rtag;

  assign {in_op, in_norm, in_val, in_home, in_step} = pop_data_i;

  dhkv_ram #(.WIDTH(EW), .DEPTH(TABLE_SIZE)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tgt_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rtag = slot_vld_q[idx_q] ? rdata[EW-1 -: 2] : TAG_EMPTY;
  assign rkey = rdata[EW-3 -: 64];
  assign rval = rdata[SW-1:0];
  assign nsum = {1'b0, idx_q} + {1'b0, step_q};
  assign nidx = (nsum >= (IW+1)'(TABLE_SIZE)) ? IW'(nsum - (IW+1)'(TABLE_SIZE)) : IW'(nsum);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    norm_d     = norm_q;
    val_d      = val_q;
    step_d     = step_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    tomb_d     = tomb_q;
    tvld_d     = tvld_q;
    tgt_d      = tgt_q;
    tgtv_d     = tgtv_q;
    found_d    = found_q;
    hit_d      = hit_q;
    used_d     = used_q;
    slot_vld_d = slot_vld_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    status_d   = status_q;
    vout_d     = vout_q;
    raddr      = idx_q;
    we         = 1'b0;
    wdata      = {TAG_LIVE, norm_q, val_q};
    pop_ready_o = (state_q == B_IDLE);
    unique case (state_q)
      B_IDLE: begin
        raddr = in_home;
        if (pop_valid_i) begin
          op_d    = in_op;
          norm_d  = in_norm;
          val_d   = in_val;
          step_d  = in_step;
          idx_d   = in_home;
          cnt_d   = '0;
          tvld_d  = 1'b0;
          tgtv_d  = 1'b0;
          found_d = 1'b0;
          if ((in_op == OP_INSERT && used_q >= UW'(TABLE_SIZE / 2)) ||
              (in_op != OP_INSERT && in_op != OP_SEARCH && in_op != OP_DELETE)) begin
            state_d = B_COMMIT;
          end else begin
            state_d = B_PROBE;
          end
        end
      end
      B_PROBE: begin
        raddr = nidx;
        if (rtag == TAG_EMPTY) begin
          tgt_d   = tvld_q ? tomb_q : idx_q;
          tgtv_d  = 1'b1;
          state_d = B_COMMIT;
        end else if (rtag == TAG_LIVE && rkey == norm_q) begin
          tgt_d   = idx_q;
          tgtv_d  = 1'b1;
          found_d = 1'b1;
          hit_d   = rval;
          state_d = B_COMMIT;
        end else begin
          if (rtag == TAG_TOMB && !tvld_q) begin
            tomb_d = idx_q;
            tvld_d = 1'b1;
          end
          idx_d = nidx;
          cnt_d = cnt_q + PW'(1);
          if (cnt_q + PW'(1) == PW'(TABLE_SIZE)) begin
            tgt_d   = tomb_d;
            tgtv_d  = tvld_d;
            state_d = B_COMMIT;
          end
        end
      end
      B_COMMIT: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d = 1'b1;
          vout_d    = '0;
          status_d  = ST_NOTFOUND;
          state_d   = B_IDLE;
          unique case (op_q)
            OP_INSERT: begin
              if (found_q) begin
                we       = 1'b1;
                status_d = ST_UPDATED;
              end else if (tgtv_q) begin
                we                = 1'b1;
                slot_vld_d[tgt_q] = 1'b1;
                used_d            = used_q + UW'(1);
                status_d          = ST_INSERTED;
              end else begin
                status_d = ST_FULL;
              end
            end
            OP_SEARCH: begin
              if (found_q) begin
                status_d = ST_FOUND;
                vout_d   = 32'(hit_q);
              end
            end
            OP_DELETE: begin
              if (found_q) begin
                we       = 1'b1;
                wdata    = {TAG_TOMB, norm_q, val_q};
                used_d   = used_q - UW'(1);
                status_d = ST_DELETED;
              end
            end
            default: status_d = ST_NOTFOUND;
          endcase
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      used_q     <= '0;
      slot_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      slot_vld_q <= slot_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    norm_q   <= norm_d;
    val_q    <= val_d;
    step_q   <= step_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    tomb_q   <= tomb_d;
    tvld_q   <= tvld_d;
    tgt_q    <= tgt_d;
    tgtv_q   <= tgtv_d;
    found_q  <= found_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    vout_q   <= vout_d;
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.value_out = vout_q;
endmodule

/* design/double_hash_key_value_table_unit.sv */
// Hash table of key/value pairs with open addressing and double hashing. One request
// (insert-or-update, search, delete) gives one response. The front end hashes the key one
// byte a cycle and then reduces the first hash modulo the table size and the second modulo
// the table size minus one, four bits a cycle; the back end probes the slot memory one slot
// a cycle through its single read port and then commits, waiting while an earlier response
// is still untaken. The front and back ends overlap through a two-entry queue. Slots are
// empty after reset; no clearing pass is needed.
module double_hash_key_value_table_unit import dhkv_pkg::*; #(
  parameter int TABLE_SIZE  = 251,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dhkv_req_if.sink   req_i,
  dhkv_rsp_if.source rsp_o
);
  localparam int IW = $clog2(TABLE_SIZE);
  localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int QW = 2 + 64 + SW + 2 * IW;

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0] push_data, pop_data;

  dhkv_front #(
    .TABLE_SIZE(TABLE_SIZE), .KEY_BYTES(KEY_BYTES), .VALUE_WIDTH(VALUE_WIDTH),
    .IW(IW), .SW(SW), .QW(QW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  dhkv_queue #(.WIDTH(QW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  dhkv_back #(
    .TABLE_SIZE(TABLE_SIZE), .VALUE_WIDTH(VALUE_WIDTH), .IW(IW), .SW(SW), .QW(QW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .rsp_o       (rsp_o)
  );

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.status <= ST_FULL))
    else $error("Response status out of range.");

  a_value_only_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_FOUND) |-> (rsp_o.value_out == 32'd0))
    else $error("Nonzero value on a response that is not a hit.");

  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("Front end took a transaction while hashing another.");

  a_queue_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready) |=> !pop_ready)
    else $error("Back end popped while a request was in progress.");
endmodule
